// ----- hdl/sacl_pkg.sv -----
package sacl_pkg;

    localparam int ADDR_W = 32;
    localparam int SETS   = 128;
    localparam int WAYS   = 2;
    localparam int SET_W  = $clog2(SETS);

    localparam int TAG_W    = 32;
    localparam int IDX_W    = 7;
    localparam int OFFSET_W = 16;
    localparam int CNT_W    = 32;
    localparam int LFSR_W   = 16;
    localparam int CFG_W    = 6;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [4:0] OFFSET_WIDTH_RST = 5'd5;
    localparam logic [2:0] INDEX_WIDTH_RST  = 3'd7;
    localparam logic [5:0] TAG_WIDTH_RST    = 6'd20;
    localparam logic [1:0] WAYS_IN_USE_RST  = 2'd2;

    localparam logic [4:0] OFFSET_WIDTH_MAX = 5'd16;
    localparam logic [5:0] TAG_WIDTH_MAX    = 6'd32;

    typedef enum logic [1:0] {
        CFG_OFFSET_WIDTH = 2'd0,
        CFG_INDEX_WIDTH  = 2'd1,
        CFG_TAG_WIDTH    = 2'd2,
        CFG_WAYS_IN_USE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [4:0] offset_width;
        logic [2:0] index_width;
        logic [5:0] tag_width;
        logic [1:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [IDX_W-1:0]    idx;
        logic [OFFSET_W-1:0] offset;
        logic [SET_W-1:0]    set;
    } fields_t;

endpackage

// ----- hdl/sacl_split.sv -----
module sacl_split
(
    input  logic [sacl_pkg::ADDR_W-1:0] address,
    input  sacl_pkg::cfg_t              cfg,
    output sacl_pkg::fields_t           fields
);

    logic [4:0]                   ow;
    logic [5:0]                   tw;
    logic [4:0]                   tag_shift;
    logic [sacl_pkg::ADDR_W-1:0]  idx_bits;
    logic [sacl_pkg::ADDR_W-1:0]  tag_bits;
    logic [sacl_pkg::OFFSET_W:0]  offset_mask;
    logic [sacl_pkg::IDX_W:0]     idx_mask;
    logic [sacl_pkg::TAG_W:0]     tag_mask;

    // clamp oversize widths
    assign ow = (cfg.offset_width > sacl_pkg::OFFSET_WIDTH_MAX) ?
                sacl_pkg::OFFSET_WIDTH_MAX : cfg.offset_width;
    assign tw = (cfg.tag_width > sacl_pkg::TAG_WIDTH_MAX) ?
                sacl_pkg::TAG_WIDTH_MAX : cfg.tag_width;

    assign tag_shift = ow + 5'(cfg.index_width);

    assign offset_mask = ((sacl_pkg::OFFSET_W+1)'(1) << ow) - (sacl_pkg::OFFSET_W+1)'(1);
    assign idx_mask    = ((sacl_pkg::IDX_W+1)'(1) << cfg.index_width) - (sacl_pkg::IDX_W+1)'(1);
    assign tag_mask    = ((sacl_pkg::TAG_W+1)'(1) << tw) - (sacl_pkg::TAG_W+1)'(1);

    assign idx_bits = address >> ow;
    assign tag_bits = address >> tag_shift;

    assign fields.offset = address[sacl_pkg::OFFSET_W-1:0] & offset_mask[sacl_pkg::OFFSET_W-1:0];
    assign fields.idx    = idx_bits[sacl_pkg::IDX_W-1:0] & idx_mask[sacl_pkg::IDX_W-1:0];
    assign fields.tag    = tag_bits[sacl_pkg::TAG_W-1:0] & tag_mask[sacl_pkg::TAG_W-1:0];
    // SETS is a power of two: set is the low bits of the index
    assign fields.set    = sacl_pkg::SET_W'(fields.idx);

endmodule

// ----- hdl/sacl_tag_ram.sv -----
module sacl_tag_ram
#(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/set_assoc_cache_tag_lookup.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+--------------------------------------------
// address   | addr_valid / addr_stall| address
// result    | res_valid / res_stall  | hit, tag_value, set_index, line_offset,
//           |                        | victim_way, hit_count, miss_count
// config    | cfg_we                 | cfg_index, cfg_data
//
// One transaction per cycle sustained while res_stall is low; the address is accepted
// with the tag RAM read, then compare and install feed the result register.
// A same-set miss just ahead is forwarded from the last-write register, so
// back-to-back accesses to one set see the installed tag.
// Reset clears the valid bits and counters and loads the LFSR seed and the default
// config at once; tag RAM is not cleared and needs no sweep.
// A stalled result holds; the compare stage holds behind it and addr_stall
// rises only when both are full.
module set_assoc_cache_tag_lookup
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           addr_valid,
    output logic                           addr_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]    address,

    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           hit,
    output logic [sacl_pkg::TAG_W-1:0]     tag_value,
    output logic [sacl_pkg::IDX_W-1:0]     set_index,
    output logic [sacl_pkg::OFFSET_W-1:0]  line_offset,
    output logic                           victim_way,
    output logic [sacl_pkg::CNT_W-1:0]     hit_count,
    output logic [sacl_pkg::CNT_W-1:0]     miss_count,

    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [sacl_pkg::CFG_W-1:0]     cfg_data
);

    // ---------------- configuration ----------------
    sacl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_width <= sacl_pkg::OFFSET_WIDTH_RST;
            cfg_reg.index_width  <= sacl_pkg::INDEX_WIDTH_RST;
            cfg_reg.tag_width    <= sacl_pkg::TAG_WIDTH_RST;
            cfg_reg.ways_in_use  <= sacl_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (sacl_pkg::cfg_index_t'(cfg_index))
                sacl_pkg::CFG_OFFSET_WIDTH: cfg_reg.offset_width <= cfg_data[4:0];
                sacl_pkg::CFG_INDEX_WIDTH:  cfg_reg.index_width  <= cfg_data[2:0];
                sacl_pkg::CFG_TAG_WIDTH:    cfg_reg.tag_width    <= cfg_data[5:0];
                sacl_pkg::CFG_WAYS_IN_USE:  cfg_reg.ways_in_use  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // 0 and 1 mean direct mapped, 2 and 3 mean two ways
    logic two_way;
    assign two_way = cfg_reg.ways_in_use[1] && (sacl_pkg::WAYS > 1);

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic s1_adv;
    logic in_accept;

    assign s1_adv     = s1_valid_reg && (!res_valid || !res_stall);
    assign addr_stall = s1_valid_reg && !s1_adv;
    assign in_accept  = addr_valid && !addr_stall;

    // ---------------- stage 0: split and RAM read ----------------
    sacl_pkg::fields_t in_fields;

    sacl_split u_split
    (
        .address (address),
        .cfg     (cfg_reg),
        .fields  (in_fields)
    );

    sacl_pkg::fields_t s1_fields_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_fields_reg <= in_fields;
        end
    end

    // ---------------- tag RAMs, one per way ----------------
    logic [sacl_pkg::TAG_W-1:0] ram_tag [sacl_pkg::WAYS];
    logic                       wr_en;
    logic                       wr_way;

    genvar w;
    generate
        for (w = 0; w < sacl_pkg::WAYS; w++)
        begin : g_way
            sacl_tag_ram
            #(
                .DEPTH (sacl_pkg::SETS),
                .WIDTH (sacl_pkg::TAG_W)
            )
            u_ram
            (
                .clk     (clk),
                .wr_en   (wr_en && (wr_way == 1'(w))),
                .wr_addr (s1_fields_reg.set),
                .wr_data (s1_fields_reg.tag),
                .rd_en   (in_accept),
                .rd_addr (in_fields.set),
                .rd_data (ram_tag[w])
            );
        end
    endgenerate

    // ---------------- last write, for same-set forwarding ----------------
    logic                        fwd_valid_reg;
    logic [sacl_pkg::SET_W-1:0]  fwd_set_reg;
    logic                        fwd_way_reg;
    logic [sacl_pkg::TAG_W-1:0]  fwd_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_set_reg <= s1_fields_reg.set;
            fwd_way_reg <= wr_way;
            fwd_tag_reg <= s1_fields_reg.tag;
        end
    end

    // ---------------- stage 1: compare, install, count ----------------
    logic [sacl_pkg::WAYS-1:0]   valid_reg [sacl_pkg::SETS];
    logic [sacl_pkg::LFSR_W-1:0] lfsr_reg;
    logic [sacl_pkg::LFSR_W-1:0] lfsr_next;
    logic [sacl_pkg::CNT_W-1:0]  hits_reg;
    logic [sacl_pkg::CNT_W-1:0]  hits_next;
    logic [sacl_pkg::CNT_W-1:0]  misses_reg;
    logic [sacl_pkg::CNT_W-1:0]  misses_next;

    logic [sacl_pkg::TAG_W-1:0]  way_tag [sacl_pkg::WAYS];
    logic [sacl_pkg::WAYS-1:0]   set_valid;
    logic                        match0;
    logic                        match1;
    logic                        hit_c;
    logic                        way_c;

    always_comb
    begin
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            way_tag[i] = (fwd_valid_reg && fwd_set_reg == s1_fields_reg.set &&
                          fwd_way_reg == 1'(i)) ? fwd_tag_reg : ram_tag[i];
        end
    end

    assign set_valid = valid_reg[s1_fields_reg.set];
    assign match0    = set_valid[0] && (way_tag[0] == s1_fields_reg.tag);
    assign match1    = two_way && set_valid[1] && (way_tag[1] == s1_fields_reg.tag);
    assign hit_c     = match0 || match1;

    // Fibonacci LFSR, taps 16/14/13/11, stepped only on a two-way miss
    assign lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[sacl_pkg::LFSR_W-1:1]};

    assign wr_way = two_way ? lfsr_next[0] : 1'b0;
    assign wr_en  = s1_adv && !hit_c;
    assign way_c  = hit_c ? !match0 : wr_way;

    assign hits_next   = (hit_c && hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
    assign misses_next = (!hit_c && misses_reg != '1) ? misses_reg + 1'b1 : misses_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < sacl_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            lfsr_reg   <= sacl_pkg::LFSR_SEED;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else if (s1_adv)
        begin
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            if (!hit_c)
            begin
                valid_reg[s1_fields_reg.set][wr_way] <= 1'b1;
                if (two_way)
                begin
                    lfsr_reg <= lfsr_next;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic                          res_valid_reg;
    logic                          hit_reg;
    logic [sacl_pkg::TAG_W-1:0]    tag_reg;
    logic [sacl_pkg::IDX_W-1:0]    idx_reg;
    logic [sacl_pkg::OFFSET_W-1:0] offset_reg;
    logic                          way_reg;
    logic [sacl_pkg::CNT_W-1:0]    hit_count_reg;
    logic [sacl_pkg::CNT_W-1:0]    miss_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hit_reg        <= hit_c;
            tag_reg        <= s1_fields_reg.tag;
            idx_reg        <= s1_fields_reg.idx;
            offset_reg     <= s1_fields_reg.offset;
            way_reg        <= way_c;
            hit_count_reg  <= hits_next;
            miss_count_reg <= misses_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign hit         = hit_reg;
    assign tag_value   = tag_reg;
    assign set_index   = idx_reg;
    assign line_offset = offset_reg;
    assign victim_way  = way_reg;
    assign hit_count   = hit_count_reg;
    assign miss_count  = miss_count_reg;

`ifndef NO_ASSERTIONS
    // the last installed entry is always marked valid
    a_fwd_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> valid_reg[fwd_set_reg][fwd_way_reg])
        else $error("last written entry not valid");

    // direct mapped installs always go to way 0
    a_direct_way0: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !two_way) |-> (wr_way == 1'b0))
        else $error("direct mapped install outside way 0");

    // a two-way miss moves the LFSR
    a_lfsr_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && two_way) |=> (lfsr_reg != $past(lfsr_reg)))
        else $error("LFSR did not step on miss");

    // input backpressure only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        addr_stall |-> (s1_valid_reg && res_valid_reg && res_stall))
        else $error("address stalled with room in pipeline");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Half clock period, reset length, settle time after the pipe drains, run limit.
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_SIZE     = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int RANDOM_PHASES = 8;

    // One predicted lookup result, laid out like the result channel.
    typedef struct packed {
        logic                          hit;
        logic [sacl_pkg::TAG_W-1:0]    tag_value;
        logic [sacl_pkg::IDX_W-1:0]    set_index;
        logic [sacl_pkg::OFFSET_W-1:0] line_offset;
        logic                          victim_way;
        logic [sacl_pkg::CNT_W-1:0]    hit_count;
        logic [sacl_pkg::CNT_W-1:0]    miss_count;
    } lookup_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          addr_valid = 1'b0;
    logic                          addr_stall;
    logic [sacl_pkg::ADDR_W-1:0]   address    = '0;
    logic                          res_valid;
    logic                          res_stall  = 1'b0;
    logic                          hit;
    logic [sacl_pkg::TAG_W-1:0]    tag_value;
    logic [sacl_pkg::IDX_W-1:0]    set_index;
    logic [sacl_pkg::OFFSET_W-1:0] line_offset;
    logic                          victim_way;
    logic [sacl_pkg::CNT_W-1:0]    hit_count;
    logic [sacl_pkg::CNT_W-1:0]    miss_count;
    logic                          cfg_we     = 1'b0;
    sacl_pkg::cfg_index_t          cfg_index  = sacl_pkg::CFG_OFFSET_WIDTH;
    logic [sacl_pkg::CFG_W-1:0]    cfg_data   = '0;

    set_assoc_cache_tag_lookup dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .addr_valid  (addr_valid),
        .addr_stall  (addr_stall),
        .address     (address),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .hit         (hit),
        .tag_value   (tag_value),
        .set_index   (set_index),
        .line_offset (line_offset),
        .victim_way  (victim_way),
        .hit_count   (hit_count),
        .miss_count  (miss_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the cache: registers, tags, valid bits, LFSR, totals.
    // Tags are only compared while their valid bit is set, so the tag
    // array itself needs no reset value.
    // ------------------------------------------------------------------
    sacl_pkg::cfg_t              cache_cfg = '{sacl_pkg::OFFSET_WIDTH_RST,
                                               sacl_pkg::INDEX_WIDTH_RST,
                                               sacl_pkg::TAG_WIDTH_RST,
                                               sacl_pkg::WAYS_IN_USE_RST};
    logic [sacl_pkg::TAG_W-1:0]  tag_copy  [sacl_pkg::SETS*sacl_pkg::WAYS];
    bit                          tag_valid [sacl_pkg::SETS*sacl_pkg::WAYS];
    logic [sacl_pkg::LFSR_W-1:0] lfsr_copy = sacl_pkg::LFSR_SEED;
    logic [sacl_pkg::CNT_W-1:0]  hits_seen   = '0;
    logic [sacl_pkg::CNT_W-1:0]  misses_seen = '0;

    logic [sacl_pkg::ADDR_W-1:0] pending_addresses [$];
    lookup_t                     lookup_expected   [$];
    logic [sacl_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    int mismatch_count = 0;
    int cycle_count    = 0;

    function automatic logic [63:0] field_mask(input int bits);
        return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    // Effective widths after clamping the raw register values.
    function automatic int eff_offset_width();
        return (cache_cfg.offset_width > sacl_pkg::OFFSET_WIDTH_MAX) ?
               int'(sacl_pkg::OFFSET_WIDTH_MAX) : int'(cache_cfg.offset_width);
    endfunction

    function automatic int eff_tag_width();
        return (cache_cfg.tag_width > sacl_pkg::TAG_WIDTH_MAX) ?
               int'(sacl_pkg::TAG_WIDTH_MAX) : int'(cache_cfg.tag_width);
    endfunction

    function automatic int eff_ways();
        int n;
        case (cache_cfg.ways_in_use)
            2'd0:    n = 1;
            2'd3:    n = 2;
            default: n = int'(cache_cfg.ways_in_use);
        endcase
        return (n > sacl_pkg::WAYS) ? sacl_pkg::WAYS : n;
    endfunction

    // Lookup of one address: split, compare, install on miss, count.
    task automatic predict_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr,
                                  output lookup_t res);
        int         ow;
        int         iw;
        int         tw;
        int         nways;
        int         set_no;
        int         entry;
        logic [63:0] a;
        logic [63:0] offs;
        logic [63:0] idx;
        logic [63:0] tag;
        logic        found;
        logic        way;
        logic        fb;
        ow     = eff_offset_width();
        iw     = int'(cache_cfg.index_width);
        tw     = eff_tag_width();
        nways  = eff_ways();
        a      = 64'(addr);
        offs   = a & field_mask(ow);
        idx    = (a >> ow) & field_mask(iw);
        tag    = (a >> (ow + iw)) & field_mask(tw);
        set_no = int'(idx % sacl_pkg::SETS);
        found  = 1'b0;
        way    = 1'b0;
        for (int w = 0; w < nways; w++)
        begin
            entry = set_no * sacl_pkg::WAYS + w;
            if (!found && tag_valid[entry] &&
                tag_copy[entry] == tag[sacl_pkg::TAG_W-1:0])
            begin
                found = 1'b1;
                way   = w[0];
            end
        end
        if (found)
        begin
            if (hits_seen != '1)
                hits_seen = hits_seen + 1'b1;
        end
        else
        begin
            if (misses_seen != '1)
                misses_seen = misses_seen + 1'b1;
            if (nways == 2)
            begin
                // Fibonacci LFSR, taps 16/14/13/11; victim is bit 0 after the step
                fb        = lfsr_copy[0] ^ lfsr_copy[2] ^ lfsr_copy[3] ^ lfsr_copy[5];
                lfsr_copy = {fb, lfsr_copy[sacl_pkg::LFSR_W-1:1]};
                way       = lfsr_copy[0];
            end
            else
            begin
                way = 1'b0;
            end
            entry            = set_no * sacl_pkg::WAYS + int'(way);
            tag_copy[entry]  = tag[sacl_pkg::TAG_W-1:0];
            tag_valid[entry] = 1'b1;
        end
        res.hit         = found;
        res.tag_value   = tag[sacl_pkg::TAG_W-1:0];
        res.set_index   = idx[sacl_pkg::IDX_W-1:0];
        res.line_offset = offs[sacl_pkg::OFFSET_W-1:0];
        res.victim_way  = way;
        res.hit_count   = hits_seen;
        res.miss_count  = misses_seen;
    endtask

    // ------------------------------------------------------------------
    // Address driver: bursts of random length, random gaps in between.
    // The prediction is made at the edge where the transaction is taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        lookup_t res;
        if (!rst_n)
        begin
            addr_valid <= 1'b0;
        end
        else
        begin
            if (addr_valid && !addr_stall)
            begin
                predict_lookup(address, res);
                lookup_expected.push_back(res);
            end
            // A stalled transaction holds its payload; otherwise pick the next
            if (!addr_valid || !addr_stall)
            begin
                if (gap_left > 0 || pending_addresses.size() == 0)
                begin
                    addr_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    addr_valid <= 1'b1;
                    address    <= pending_addresses.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        // mostly short bursts, now and then a long back-to-back run
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall mode is picked at random and held for a random span
    // (free flowing, light, heavy, solid).
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_span = 20;

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = (stall_mode == 3) ? $urandom_range(2, 30) : $urandom_range(5, 60);
        end
        else
        begin
            stall_span--;
        end
        case (stall_mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Result monitor: each taken result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (lookup_expected.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding, expected none, actual %h",
                         $time, tag_value);
                mismatch_count++;
            end
            else
            begin
                want = lookup_expected.pop_front();
                check_field("hit",         32'(want.hit),         32'(hit));
                check_field("tag_value",   want.tag_value,        tag_value);
                check_field("set_index",   32'(want.set_index),   32'(set_index));
                check_field("line_offset", 32'(want.line_offset), 32'(line_offset));
                check_field("victim_way",  32'(want.victim_way),  32'(victim_way));
                check_field("hit_count",   want.hit_count,        hit_count);
                check_field("miss_count",  want.miss_count,       miss_count);
            end
        end
    end

    // Hard stop if the pipe hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Sender holds off until every transaction has come back, then waits out the
    // settle time so the compare stage is empty before a register write.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_addresses.size() != 0 || addr_valid || lookup_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; the shadow copy takes
    // the same register-width masking as the hardware.
    task automatic program_cache(input logic [sacl_pkg::CFG_W-1:0] ow,
                                 input logic [sacl_pkg::CFG_W-1:0] iw,
                                 input logic [sacl_pkg::CFG_W-1:0] tw,
                                 input logic [sacl_pkg::CFG_W-1:0] nw);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sacl_pkg::CFG_OFFSET_WIDTH;
        cfg_data  <= ow;
        cache_cfg.offset_width = ow[4:0];
        @(posedge clk);
        cfg_index <= sacl_pkg::CFG_INDEX_WIDTH;
        cfg_data  <= iw;
        cache_cfg.index_width = iw[2:0];
        @(posedge clk);
        cfg_index <= sacl_pkg::CFG_TAG_WIDTH;
        cfg_data  <= tw;
        cache_cfg.tag_width = tw[5:0];
        @(posedge clk);
        cfg_index <= sacl_pkg::CFG_WAYS_IN_USE;
        cfg_data  <= nw;
        cache_cfg.ways_in_use = nw[1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random address shaped to the current field layout: mostly reuse of a
    // small working set so lines hit, conflict and get evicted.
    function automatic logic [sacl_pkg::ADDR_W-1:0] make_address();
        int                          ow;
        int                          base;
        int                          pick;
        int                          slot;
        logic [sacl_pkg::ADDR_W-1:0] a;
        ow   = eff_offset_width();
        base = ow + int'(cache_cfg.index_width);
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        a    = addr_pool[slot];
        if (pick < 40)
        begin
            // same line, new offset
            a = a ^ (sacl_pkg::ADDR_W'($urandom) & sacl_pkg::ADDR_W'(field_mask(ow)));
        end
        else if (pick < 65)
        begin
            // same set, one of a few tags -> conflicts on two ways
            if (base + 1 < sacl_pkg::ADDR_W)
                a = a ^ (sacl_pkg::ADDR_W'($urandom_range(0, 3)) << base);
        end
        else if (pick < 72)
        begin
            // bits above the tag field; must not change the lookup
            a = a ^ (sacl_pkg::ADDR_W'($urandom) << (base + eff_tag_width()));
        end
        else if (pick < 85)
        begin
            addr_pool[slot] = $urandom;
            a = addr_pool[slot];
        end
        else
        begin
            a = $urandom;
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [sacl_pkg::CFG_W-1:0] ow;
        logic [sacl_pkg::CFG_W-1:0] iw;
        logic [sacl_pkg::CFG_W-1:0] tw;
        logic [sacl_pkg::CFG_W-1:0] nw;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout: cold zero tag must miss, then hit; one set with
        // three tags cycling through its two ways.
        pending_addresses = '{32'h0000_0000, 32'h0000_0000, 32'h0000_001F,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                              32'h5555_5555, 32'h0000_1000, 32'h0000_2000,
                              32'h0000_3000, 32'h0000_1000, 32'h0000_0000};
        wait_idle();

        // Offset and tag widths above their maximum, no index, ways zero
        program_cache(6'h3F, 6'h00, 6'h3F, 6'h00);
        pending_addresses = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h0000_0000};
        wait_idle();

        // Zero offset, zero tag width, ways three
        program_cache(6'h00, 6'h07, 6'h00, 6'h03);
        pending_addresses = '{32'h0000_007F, 32'hFFFF_FF7F, 32'h0000_0080, 32'h0000_0055};
        wait_idle();

        // Widest legal layout, direct mapped; way 1 contents left from before
        program_cache(6'd16, 6'd7, 6'd32, 6'd1);
        pending_addresses = '{32'hFFFF_FFFF, 32'h0180_0000};
        wait_idle();

        // Random phases: extremes and a mid layout first, then random register data
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ow = 6'd0;  iw = 6'd0; tw = 6'd1;  nw = 6'd1;
                end
                1:
                begin
                    ow = 6'd16; iw = 6'd7; tw = 6'd32; nw = 6'd2;
                end
                2:
                begin
                    ow = 6'h3F; iw = 6'h3F; tw = 6'h3F; nw = 6'h3F;
                end
                3:
                begin
                    ow = 6'd5;  iw = 6'd4; tw = 6'd3;  nw = 6'd2;
                end
                default:
                begin
                    ow = 6'($urandom_range(0, 63));
                    iw = 6'($urandom_range(0, 63));
                    tw = 6'($urandom_range(0, 63));
                    nw = 6'($urandom_range(0, 63));
                end
            endcase
            program_cache(ow, iw, tw, nw);
            foreach (addr_pool[i])
                addr_pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_addresses.push_back(make_address());
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- set_assoc_cache_tag_lookup.f -----
hdl/sacl_pkg.sv
hdl/sacl_split.sv
hdl/sacl_tag_ram.sv
hdl/set_assoc_cache_tag_lookup.sv
test/testbench.sv
